// ===== src/lfr_pkg.sv =====
// Shared constants, register codes and control types for the Lagrange resampler.
// No dependencies; used by every module under src.
package lfr_pkg;

   localparam int SampleBits = 24;
   localparam int FracBits   = 16;
   localparam int Taps       = 6;
   localparam int Lanes      = 2;
   localparam int MaxOut     = 8;

   localparam int PitchStepW    = 19;
   localparam int ChannelCountW = 2;
   localparam int CsrAddrW      = 1;
   localparam int CsrDataW      = 19;

   localparam logic [CsrAddrW-1:0] CsrPitchStep    = 1'd0;
   localparam logic [CsrAddrW-1:0] CsrChannelCount = 1'd1;

   localparam logic [PitchStepW-1:0]    PitchStepReset    = 19'd65536;
   localparam logic [ChannelCountW-1:0] ChannelCountReset = 2'd2;
   localparam logic [ChannelCountW-1:0] ChannelsStereo    = 2'd2;

   // hand-off from the sequencer to the output stage
   typedef struct packed {
      logic push;
      logic last;
      logic mono;
   } lfr_ctl_type;

endpackage

// ===== src/lfr_lane.sv =====
// One interpolation lane: coefficient set-up, Horner iteration on a shared multiplier,
// rounding divide by 120 and saturation. Depends on lfr_pkg.
module lfr_lane #(
   parameter int SAMPLE_BITS = lfr_pkg::SampleBits,
   parameter int FRAC_BITS   = lfr_pkg::FracBits
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [FRAC_BITS-1:0]                        frac,
   input  logic [lfr_pkg::Taps-1:0][SAMPLE_BITS-1:0]   taps,
   output logic                                        done,
   output logic [SAMPLE_BITS-1:0]                      result
);

   localparam int SW         = SAMPLE_BITS;
   localparam int TqBits     = (FRAC_BITS > 16) ? 16 : FRAC_BITS;
   localparam int CW         = SW + 9;
   localparam int AW         = SW + 12;
   localparam int PWd        = AW + TqBits + 1;
   localparam int QW         = SW + 4;
   localparam int RecipShift = QW + 4;
   localparam int MW         = RecipShift - 3;
   localparam int KW         = 3;

   localparam logic [63:0]          RecipFull = ((64'd1 << RecipShift) + 64'd14) / 64'd15;
   localparam logic [MW-1:0]        RecipM    = RecipFull[MW-1:0];
   localparam logic signed [AW-1:0] DivOff    = AW'(64'sd15 <<< (SW - 1));
   localparam logic signed [AW-1:0] YMax      = AW'((64'sd15 <<< SW) - 64'sd1);
   localparam logic signed [AW-1:0] Sixty     = AW'(60);
   localparam logic signed [PWd-1:0] HalfQ    = PWd'(64'sd1 <<< (TqBits - 1));

   typedef enum logic [5:0] {
      L_IDLE  = 6'b000001,
      L_MUL   = 6'b000010,
      L_ADD   = 6'b000100,
      L_SCALE = 6'b001000,
      L_RECIP = 6'b010000,
      L_DONE  = 6'b100000
   } lane_state_type;

   lane_state_type          state_ff, state_in;
   logic signed [CW-1:0]    coef_ff [5];
   logic signed [CW-1:0]    coef_in [5];
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [PWd-1:0]   prod_ff, prod_in;
   logic [TqBits-1:0]       tq_ff, tq_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [QW-1:0]           yq_ff, yq_in;
   logic [SW-1:0]           res_ff, res_in;

   logic signed [CW-1:0]    ym2, ym1, y0, y1, y2, y3;
   logic signed [CW-1:0]    c0, c1, c2, c3, c4, c5;
   logic signed [PWd-1:0]   rnd;
   logic signed [AW-1:0]    acc_add;
   logic signed [AW-1:0]    ys, yo;
   logic [QW+MW-1:0]        recip_prod;
   logic [SW-1:0]           quot;

   assign ym2 = CW'($signed(taps[0]));
   assign ym1 = CW'($signed(taps[1]));
   assign y0  = CW'($signed(taps[2]));
   assign y1  = CW'($signed(taps[3]));
   assign y2  = CW'($signed(taps[4]));
   assign y3  = CW'($signed(taps[5]));

   // polynomial coefficients, all scaled by 120
   assign c0 = CW'(120 * y0);
   assign c1 = CW'(6 * ym2 - 60 * ym1 - 40 * y0 + 120 * y1 - 30 * y2 + 4 * y3);
   assign c2 = CW'(80 * (ym1 + y1) - 150 * y0 - 5 * (ym2 + y2));
   assign c3 = CW'(50 * y0 - 70 * y1 + 35 * y2 - 5 * (ym2 + ym1 + y3));
   assign c4 = CW'(30 * y0 - 20 * (ym1 + y1) + 5 * (ym2 + y2));
   assign c5 = CW'((y3 - ym2) + 5 * (ym1 - y2) + 10 * (y1 - y0));

   assign rnd     = prod_ff + HalfQ;
   assign acc_add = AW'(rnd >>> TqBits) + AW'(coef_ff[k_ff]);

   // floor((acc + 60) / 120) = floor(floor((acc + 60) / 8) / 15); offset to non-negative
   assign ys = (acc_ff + Sixty) >>> 3;
   assign yo = ys + DivOff;

   assign recip_prod = (QW+MW)'(yq_ff) * (QW+MW)'(RecipM);
   assign quot       = recip_prod[RecipShift +: SW];

   always_comb begin
      state_in = state_ff;
      coef_in  = coef_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      tq_in    = tq_ff;
      k_in     = k_ff;
      yq_in    = yq_ff;
      res_in   = res_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               coef_in[0] = c0;
               coef_in[1] = c1;
               coef_in[2] = c2;
               coef_in[3] = c3;
               coef_in[4] = c4;
               acc_in     = AW'(c5);
               tq_in      = frac[FRAC_BITS-1 -: TqBits];
               k_in       = KW'(4);
               if (frac == '0) begin
                  res_in   = taps[2];
                  state_in = L_DONE;
               end else begin
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            prod_in  = acc_ff * $signed({1'b0, tq_ff});
            state_in = L_ADD;
         end
         L_ADD: begin
            acc_in = acc_add;
            if (k_ff == '0) begin
               state_in = L_SCALE;
            end else begin
               k_in     = k_ff - KW'(1);
               state_in = L_MUL;
            end
         end
         L_SCALE: begin
            // clamping here is the saturation
            if (yo[AW-1]) begin
               yq_in = '0;
            end else if (yo > YMax) begin
               yq_in = QW'(YMax);
            end else begin
               yq_in = QW'(yo);
            end
            state_in = L_RECIP;
         end
         L_RECIP: begin
            res_in   = {~quot[SW-1], quot[SW-2:0]};
            state_in = L_DONE;
         end
         L_DONE: begin
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      tq_ff   <= tq_in;
      k_ff    <= k_in;
      yq_ff   <= yq_in;
      res_ff  <= res_in;
   end

   assign done   = (state_ff == L_DONE);
   assign result = res_ff;

endmodule

// ===== src/lfr_merge.sv =====
// Output stage: joins the two lane results into one result beat and holds it
// until taken. Depends on lfr_pkg.
module lfr_merge #(
   parameter int SAMPLE_BITS = lfr_pkg::SampleBits
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lfr_pkg::lfr_ctl_type      ctl,
   input  logic [SAMPLE_BITS-1:0]    left,
   input  logic [SAMPLE_BITS-1:0]    right,
   output logic                      ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_out_left,
   output logic [SAMPLE_BITS-1:0]    rsp_out_right,
   output logic                      rsp_last_of_run
);

   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] left_ff;
   logic [SAMPLE_BITS-1:0] right_ff;
   logic                   last_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         left_ff  <= left;
         right_ff <= ctl.mono ? '0 : right;
         last_ff  <= ctl.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_left    = left_ff;
   assign rsp_out_right   = right_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== src/lagrange_fractional_resampler_top.sv =====
// Top level of the 6-point Lagrange fractional resampler: history, read position,
// sequencer, two lanes and output stage. Depends on lfr_pkg, lfr_lane, lfr_merge.
//
//   port group   dir   beat contents
//   req_*        in    sample_left, sample_right (one audio frame)
//   rsp_*        out   out_left, out_right, last_of_run (one interpolated frame)
//   csr_*        in    pitch_step (index 0), channel_count (index 1)
//
// An input frame yields n = 0..8 results; output stalls can hold it longer. A result
// goes through five multiply/add pairs, scale, reciprocal divide, done and hand-off
// to the output stage; a zero fraction goes straight to done. Lanes run in lockstep.
// A result waiting in the output stage does not block the next frame; rsp_stall holds
// the sequencer only when a new result is ready.
// Synchronous reset clears history and read position, resets CSRs; no clearing pass.
module lagrange_fractional_resampler_top #(
   parameter int SAMPLE_BITS = lfr_pkg::SampleBits,
   parameter int FRAC_BITS   = lfr_pkg::FracBits
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample_left,
   input  logic [SAMPLE_BITS-1:0]             req_sample_right,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [SAMPLE_BITS-1:0]             rsp_out_left,
   output logic [SAMPLE_BITS-1:0]             rsp_out_right,
   output logic                               rsp_last_of_run,
   input  logic                               csr_wen,
   input  logic [lfr_pkg::CsrAddrW-1:0]       csr_addr,
   input  logic [lfr_pkg::CsrDataW-1:0]       csr_wdata
);

   localparam int SW      = SAMPLE_BITS;
   localparam int PW      = FRAC_BITS + 4;
   localparam int StepW   = FRAC_BITS + 3;
   localparam int HistLen = lfr_pkg::Taps + 1;
   localparam int CmpW    = (StepW > lfr_pkg::PitchStepW) ? StepW : lfr_pkg::PitchStepW;
   localparam int CntW    = $clog2(lfr_pkg::MaxOut);

   localparam logic signed [PW-1:0] PosOne   = PW'(64'sd1 <<< FRAC_BITS);
   localparam logic [CmpW-1:0]      StepMinX = CmpW'(64'd1 << (FRAC_BITS - 3));
   localparam logic [CmpW-1:0]      StepMaxX = CmpW'(64'd4 << FRAC_BITS);
   localparam logic [CntW-1:0]      CntLast  = CntW'(lfr_pkg::MaxOut - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_RUN   = 4'b0100,
      S_OUT   = 4'b1000
   } top_state_type;

   top_state_type                        state_ff, state_in;
   logic signed [PW-1:0]                 pos_ff, pos_in;
   logic [CntW-1:0]                      cnt_ff, cnt_in;
   logic [lfr_pkg::PitchStepW-1:0]       step_ff;
   logic [lfr_pkg::ChannelCountW-1:0]    chan_ff;
   logic [SW-1:0]                        hist_ff [2][HistLen];

   logic                                 stereo;
   logic                                 accept;
   logic [CmpW-1:0]                      step_x;
   logic [StepW-1:0]                     step_c;
   logic signed [PW-1:0]                 pos_next;
   logic                                 last;
   logic signed [PW-1:0]                 start_pos;
   logic signed [PW-1:0]                 frac_full;
   logic [FRAC_BITS-1:0]                 frac;
   logic                                 lane_start;
   logic [1:0]                           lane_done;
   logic [SW-1:0]                        lane_res [2];
   logic [lfr_pkg::Taps-1:0][SW-1:0]     lane_taps [2];
   logic                                 merge_ready;
   lfr_pkg::lfr_ctl_type                 ctl;

   assign stereo    = (chan_ff == lfr_pkg::ChannelsStereo);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // pitch step saturated to 0.125 .. 4.0
   assign step_x = CmpW'(step_ff);
   always_comb begin
      if (step_x < StepMinX) begin
         step_c = StepW'(StepMinX);
      end else if (step_x > StepMaxX) begin
         step_c = StepW'(StepMaxX);
      end else begin
         step_c = StepW'(step_x);
      end
   end

   assign pos_next  = pos_ff + $signed({1'b0, step_c});
   assign last      = !pos_next[PW-1] || (cnt_ff == CntLast);
   assign start_pos = (state_ff == S_OUT) ? pos_next : pos_ff;
   assign frac_full = start_pos + PosOne;
   assign frac      = frac_full[PW-1] ? '0 : frac_full[FRAC_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      lane_start = 1'b0;
      ctl.push   = 1'b0;
      ctl.last   = last;
      ctl.mono   = !stereo;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in   = pos_ff - PosOne;
               cnt_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pos_ff[PW-1]) begin
               lane_start = 1'b1;
               state_in   = S_RUN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RUN: begin
            if (&lane_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (merge_ready) begin
               ctl.push = 1'b1;
               pos_in   = pos_next;
               cnt_in   = cnt_ff + CntW'(1);
               if (last) begin
                  state_in = S_IDLE;
               end else begin
                  lane_start = 1'b1;
                  state_in   = S_RUN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lfr_pkg::PitchStepReset;
         chan_ff <= lfr_pkg::ChannelCountReset;
      end else if (csr_wen) begin
         unique case (csr_addr)
            lfr_pkg::CsrPitchStep:    step_ff <= csr_wdata[lfr_pkg::PitchStepW-1:0];
            lfr_pkg::CsrChannelCount: chan_ff <= csr_wdata[lfr_pkg::ChannelCountW-1:0];
            default: ;
         endcase
      end
   end

   // seven-frame history per channel, newest at index 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < 2; g++) begin
            for (int i = 0; i < HistLen; i++) begin
               hist_ff[g][i] <= '0;
            end
         end
      end else if (accept) begin
         for (int g = 0; g < 2; g++) begin
            for (int i = HistLen - 1; i > 0; i--) begin
               hist_ff[g][i] <= hist_ff[g][i-1];
            end
         end
         hist_ff[0][0] <= req_sample_left;
         hist_ff[1][0] <= stereo ? req_sample_right : '0;
      end
   end

   // lane taps run oldest first: second to seventh newest frame
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         for (int j = 0; j < lfr_pkg::Taps; j++) begin
            lane_taps[g][j] = hist_ff[g][lfr_pkg::Taps - j];
         end
      end
   end

   for (genvar g = 0; g < lfr_pkg::Lanes; g++) begin : g_lane
      lfr_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .FRAC_BITS   (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .frac   (frac),
         .taps   (lane_taps[g]),
         .done   (lane_done[g]),
         .result (lane_res[g])
      );
   end

   lfr_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .left            (lane_res[0]),
      .right           (lane_res[1]),
      .ready           (merge_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_left    (rsp_out_left),
      .rsp_out_right   (rsp_out_right),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assert property (@(posedge clock) disable iff (reset)
      lane_done[0] == lane_done[1])
      else $error("lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.push && ctl.last) |=> !req_stall)
      else $error("sequencer not idle after last beat of a run");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.push && ctl.last && cnt_ff != CntLast) |=> !pos_ff[PW-1])
      else $error("run ended with read position still negative");

endmodule

// ===== sim/lfr_tb_pkg.sv =====
// Scoreboard for the Lagrange resampler bench: a bit-exact predictor of the
// resampled frames and an in-order comparison against the DUT's result beats.
// Depends on lfr_pkg for widths, register indexes and the stereo code.
package lfr_tb_pkg;
   import lfr_pkg::*;

   localparam int     HistLen    = Taps + 1;
   localparam int     TqBits     = (FracBits > 16) ? 16 : FracBits;
   localparam int     PosOne     = 1 << FracBits;
   localparam int     StepFloor  = 1 << (FracBits - 3);
   localparam int     StepCeil   = 4 << FracBits;
   localparam longint SampleMax  = (longint'(1) << (SampleBits - 1)) - 1;
   localparam longint SampleMin  = -SampleMax - 1;
   localparam int     MaxReports = 10;

   typedef struct packed {
      logic [SampleBits-1:0] out_left;
      logic [SampleBits-1:0] out_right;
      logic                  last_of_run;
   } resampled_frame_type;

   class resample_scoreboard_type;
      longint                   history[Lanes][HistLen];
      int                       read_position;
      logic [PitchStepW-1:0]    pitch_step;
      logic [ChannelCountW-1:0] channel_count;
      resampled_frame_type      pending_frames[$];
      int unsigned              frames_in;
      int unsigned              frames_checked;
      int unsigned              failures;

      function new();
         foreach (history[c, i]) history[c][i] = 0;
         read_position  = 0;
         pitch_step     = PitchStepReset;
         channel_count  = ChannelCountReset;
         frames_in      = 0;
         frames_checked = 0;
         failures       = 0;
      endfunction

      function void write_reg(logic [CsrAddrW-1:0] idx, logic [CsrDataW-1:0] val);
         if (idx == CsrPitchStep) begin
            pitch_step = val[PitchStepW-1:0];
         end else if (idx == CsrChannelCount) begin
            channel_count = val[ChannelCountW-1:0];
         end
      endfunction

      // 6-point Lagrange between y0 and y1, coefficients scaled by 120
      function longint lagrange_point(int lane, longint frac);
         longint ym2, ym1, y0, y1, y2, y3, acc, r, tq;
         longint coef[6];
         int     k;
         ym2 = history[lane][6];
         ym1 = history[lane][5];
         y0  = history[lane][4];
         y1  = history[lane][3];
         y2  = history[lane][2];
         y3  = history[lane][1];
         if (frac == 0) return y0;
         coef[0] = 120 * y0;
         coef[1] = 6 * ym2 - 60 * ym1 - 40 * y0 + 120 * y1 - 30 * y2 + 4 * y3;
         coef[2] = 80 * (ym1 + y1) - 150 * y0 - 5 * (ym2 + y2);
         coef[3] = 50 * y0 - 70 * y1 + 35 * y2 - 5 * (ym2 + ym1 + y3);
         coef[4] = 30 * y0 - 20 * (ym1 + y1) + 5 * (ym2 + y2);
         coef[5] = (y3 - ym2) + 5 * (ym1 - y2) + 10 * (y1 - y0);
         tq  = frac >>> (FracBits - TqBits);
         acc = coef[5];
         for (k = 4; k >= 0; k--) begin
            acc = ((acc * tq + (longint'(1) << (TqBits - 1))) >>> TqBits) + coef[k];
         end
         r = acc + 60;
         r = (r >= 0) ? r / 120 : -((-r + 119) / 120);
         if (r > SampleMax) r = SampleMax;
         if (r < SampleMin) r = SampleMin;
         return r;
      endfunction

      function void note_frame(logic [SampleBits-1:0] left, logic [SampleBits-1:0] right);
         bit                  stereo;
         int                  step;
         int                  n;
         int                  lane;
         int                  i;
         longint              frac;
         longint              lval;
         longint              rval;
         resampled_frame_type beat;
         stereo = (channel_count == ChannelsStereo);
         step   = int'(pitch_step);
         if (step < StepFloor) step = StepFloor;
         if (step > StepCeil) step = StepCeil;
         frames_in++;
         for (lane = 0; lane < Lanes; lane++) begin
            for (i = HistLen - 1; i > 0; i--) history[lane][i] = history[lane][i - 1];
         end
         history[0][0] = longint'($signed(left));
         history[1][0] = stereo ? longint'($signed(right)) : 0;
         read_position -= PosOne;
         n = 0;
         while (read_position < 0 && n < MaxOut) begin
            frac = read_position + PosOne;
            if (frac < 0) frac = 0;
            lval = lagrange_point(0, frac);
            rval = stereo ? lagrange_point(1, frac) : 0;
            beat.out_left    = lval[SampleBits-1:0];
            beat.out_right   = rval[SampleBits-1:0];
            beat.last_of_run = !((read_position + step) < 0 && (n + 1) < MaxOut);
            pending_frames.push_back(beat);
            n++;
            read_position += step;
         end
      endfunction

      function void check_result(logic [SampleBits-1:0] left, logic [SampleBits-1:0] right,
                                 logic last);
         resampled_frame_type want;
         if (pending_frames.size() == 0) begin
            failures++;
            if (failures <= MaxReports)
               $display("unexpected result beat: left %0d right %0d last %0b",
                        $signed(left), $signed(right), last);
            return;
         end
         want = pending_frames.pop_front();
         frames_checked++;
         if (want.out_left !== left || want.out_right !== right ||
             want.last_of_run !== last) begin
            failures++;
            if (failures <= MaxReports) begin
               $display("beat %0d mismatch: expected left %0d right %0d last %0b,",
                        frames_checked, $signed(want.out_left), $signed(want.out_right),
                        want.last_of_run);
               $display("   got left %0d right %0d last %0b",
                        $signed(left), $signed(right), last);
            end
         end
      endfunction

      function int pending();
         return pending_frames.size();
      endfunction
   endclass

endpackage

// ===== sim/testbench.sv =====
// Top of the resampler bench: clock, reset, directed corner frames, random
// register settings and samples, bursty input and a stalling output side.
// Depends on lfr_pkg, lfr_tb_pkg and lagrange_fractional_resampler_top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lfr_pkg::*;
   import lfr_tb_pkg::*;

   localparam int RandomFrames = 200;
   localparam int SettleCycles = 150;
   localparam int IdleLimit    = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SampleBits-1:0] req_sample_left = '0;
   logic [SampleBits-1:0] req_sample_right = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SampleBits-1:0] rsp_out_left;
   logic [SampleBits-1:0] rsp_out_right;
   logic                  rsp_last_of_run;
   logic                  csr_wen = 1'b0;
   logic [CsrAddrW-1:0]   csr_addr = '0;
   logic [CsrDataW-1:0]   csr_wdata = '0;

   resample_scoreboard_type sb;
   int unsigned        burst_left = 0;
   int unsigned        idle_cycles = 0;
   int unsigned        settings_used = 0;
   int unsigned        stall_mode = 0;
   int unsigned        stall_left = 0;
   int unsigned        mode_left = 0;

   logic [SampleBits-1:0] corner_samples[8] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                                24'h000001, 24'h555555, 24'hAAAAAA, 24'h7FFFFE};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lagrange_fractional_resampler_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_wen          (csr_wen),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   // output stall: modes swap at random intervals, one of them never stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(64, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: begin
            if (stall_left != 0) begin
               rsp_stall  <= 1'b1;
               stall_left <= stall_left - 1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
            end
         end
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_left, rsp_out_right, rsp_last_of_run);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IdleLimit) @(posedge clock);
      $display("no beat accepted for %0d cycles, %0d results outstanding", IdleLimit, sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [SampleBits-1:0] random_sample();
      int s;
      logic [SampleBits-1:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = corner_samples[$urandom_range(0, 7)];
         2, 3: begin
            s = int'($urandom_range(0, 511)) - 256;
            v = s[SampleBits-1:0];
         end
         default: v = SampleBits'($urandom());
      endcase
      return v;
   endfunction

   // input frames go in bursts; a gap of random length may open each burst
   task automatic send_frame(input logic [SampleBits-1:0] left, input logic [SampleBits-1:0] right);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_sample_left  <= left;
      req_sample_right <= right;
      do @(posedge clock); while (req_stall);
      sb.note_frame(left, right);
   endtask

   // wait for every predicted beat, then let a frame with no result finish
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_settings(input logic [PitchStepW-1:0] step,
                                 input logic [ChannelCountW-1:0] chans);
      csr_wen   <= 1'b1;
      csr_addr  <= CsrPitchStep;
      csr_wdata <= CsrDataW'(step);
      @(posedge clock);
      sb.write_reg(CsrPitchStep, CsrDataW'(step));
      csr_addr  <= CsrChannelCount;
      csr_wdata <= CsrDataW'(chans);
      @(posedge clock);
      sb.write_reg(CsrChannelCount, CsrDataW'(chans));
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      int unsigned           sent;
      int unsigned           count;
      int unsigned           k;
      logic [PitchStepW-1:0] step;
      logic [ChannelCountW-1:0] chans;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unit step, so every output is a pass-through
      for (k = 0; k < 8; k++) send_frame(corner_samples[k], corner_samples[7 - k]);

      // step below the floor clamps to 0.125: eight outputs per frame, overshoot saturates
      settle();
      write_settings('0, ChannelsStereo);
      for (k = 0; k < 6; k++)
         send_frame(k[0] ? 24'h800000 : 24'h7FFFFF, k[0] ? 24'h7FFFFF : 24'h800000);

      // largest register value clamps to 4.0, mono
      settle();
      write_settings('1, 2'd1);
      for (k = 0; k < 6; k++) send_frame(corner_samples[k + 2], corner_samples[k]);

      // channel count 3 also means mono; 1.5 step gives half-frame fractions
      settle();
      write_settings(19'd98304, 2'd3);
      for (k = 0; k < 5; k++) send_frame(corner_samples[(k * 3) % 8], 24'hFFFFFF);

      sent = 0;
      while (sent < RandomFrames) begin
         case ($urandom_range(0, 7))
            0: step = 19'd8192;
            1: step = 19'd262144;
            2: step = 19'd65536;
            3: step = PitchStepW'($urandom_range(0, 8191));
            4: step = PitchStepW'($urandom_range(262145, 524287));
            default: step = PitchStepW'($urandom_range(8192, 262144));
         endcase
         case ($urandom_range(0, 5))
            3: chans = 2'd1;
            4: chans = 2'd0;
            5: chans = 2'd3;
            default: chans = ChannelsStereo;
         endcase
         settle();
         write_settings(step, chans);
         count = $urandom_range(8, 30);
         for (k = 0; k < count; k++) send_frame(random_sample(), random_sample());
         sent += count;
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("%0d input frames, %0d resampled frames compared, %0d register settings",
               sb.frames_in, sb.frames_checked, settings_used);
      $display("steps from clamped-low to clamped-high, mono and stereo, with both sides stalling");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatching or unexpected beats", sb.failures);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
